/* rtl/core/tcbl_pkg.sv */
`default_nettype none

package tcbl_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_BASE  = 2'd1;
    localparam logic [1:0] KIND_THR   = 2'd2;

    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    localparam int          RAMP_STEPS   = 50;
    localparam logic [5:0]  RAMP_MAX     = 6'(RAMP_STEPS);
    localparam int          RECIP_SHIFT  = 20;
    localparam logic [14:0] RECIP        = 15'((2**RECIP_SHIFT + RAMP_STEPS - 1) / RAMP_STEPS);

    localparam logic [7:0]  BASE_RESET   = 8'd150;
    localparam int          PRESET_COUNT = 5;
    localparam t_rgb        PRESET [PRESET_COUNT] = '{
        '{8'd255, 8'd0,   8'd0},
        '{8'd0,   8'd255, 8'd0},
        '{8'd0,   8'd0,   8'd255},
        '{8'd255, 8'd255, 8'd0},
        '{8'd255, 8'd0,   8'd255}
    };

    localparam int          REG_GROUP_COUNT = 0;
    localparam int          REG_THR_COUNT   = 1;

endpackage

`default_nettype wire

/* rtl/core/threshold_color_breathing_led.sv */
// Write requests (base color, threshold entry) and ignored kinds leave the FSM idle.
// A frame request scans the active thresholds from the top; a match sends out
// that threshold's color, else breathing mode scales each base component by the step.
// Requests are taken only in idle; a result stalled by i_ready
// holds off the next request. One comparator and one multiplier are shared.
// Synchronous active-low reset restores the tables, registers and ramp state.
`default_nettype none

module threshold_color_breathing_led #(
    parameter int GROUP_ENTRIES     = 15,
    parameter int THRESHOLD_ENTRIES = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic             o_pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_sensor_sample,
    input  wire logic [3:0]  i_entry_index,
    input  wire logic [15:0] i_threshold_level,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [7:0]  o_red_out,
    output logic      [7:0]  o_green_out,
    output logic      [7:0]  o_blue_out,
    output logic             o_threshold_mode,
    output logic      [3:0]  o_matched_threshold,
    output logic      [3:0]  o_active_group,
    output logic      [5:0]  o_ramp_step
);

    localparam int GCW = $clog2(GROUP_ENTRIES + 1);
    localparam int GIW = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
    localparam int TCW = $clog2(THRESHOLD_ENTRIES + 1);
    localparam int TIW = (THRESHOLD_ENTRIES > 1) ? $clog2(THRESHOLD_ENTRIES) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [3:0]         r_grp_count;
    logic [3:0]         r_thr_count;

    tcbl_pkg::t_rgb     r_base    [GROUP_ENTRIES];
    logic [15:0]        r_thr_lvl [THRESHOLD_ENTRIES];
    tcbl_pkg::t_rgb     r_thr_col [THRESHOLD_ENTRIES];

    logic [2:0]         r_state;
    logic [15:0]        r_sample;
    logic [TCW-1:0]     r_idx;
    logic [TIW-1:0]     r_match;
    logic               r_found;
    logic [1:0]         r_k;
    logic [13:0]        r_acc;
    tcbl_pkg::t_rgb     r_col;

    logic [GIW-1:0]     r_grp;
    logic [5:0]         r_step;
    logic               r_falling;
    logic               r_last_mode;

    logic               r_out_valid;
    tcbl_pkg::t_rgb     r_out_col;
    logic               r_out_mode;
    logic [3:0]         r_out_match;
    logic [3:0]         r_out_group;
    logic [5:0]         r_out_step;

    logic [GCW-1:0]     w_ngroups;
    logic [TCW-1:0]     w_nthr;
    logic               w_cfg_wr;
    logic               w_accept;
    logic [TIW-1:0]     w_scan_addr;
    logic               w_hit;
    logic [7:0]         w_base_comp;
    logic [13:0]        w_op_a;
    logic [14:0]        w_op_b;
    logic [28:0]        w_mul;
    logic               w_out_load;
    logic [GCW-1:0]     w_grp_inc;
    logic [5:0]         n_step;
    logic               n_falling;
    logic [GIW-1:0]     n_grp;

    assign w_ngroups = (7'(r_grp_count) > 7'(GROUP_ENTRIES)) ? GCW'(GROUP_ENTRIES)
                                                             : GCW'(r_grp_count);
    assign w_nthr    = (7'(r_thr_count) > 7'(THRESHOLD_ENTRIES)) ? TCW'(THRESHOLD_ENTRIES)
                                                                 : TCW'(r_thr_count);

    assign w_cfg_wr  = i_psel && i_penable && i_pwrite;
    assign o_pready  = 1'b1;
    assign o_prdata  = i_paddr[2] ? {28'd0, r_thr_count} : {28'd0, r_grp_count};

    assign o_ready   = (r_state == ST_IDLE);
    assign w_accept  = i_valid && o_ready;

    assign w_scan_addr = TIW'(r_idx - TCW'(1));
    assign w_hit       = (r_idx != '0) && (r_sample >= r_thr_lvl[w_scan_addr]);

    always_comb begin
        case (r_k)
            tcbl_pkg::COMP_RED:   w_base_comp = r_base[r_grp].red;
            tcbl_pkg::COMP_GREEN: w_base_comp = r_base[r_grp].green;
            default:              w_base_comp = r_base[r_grp].blue;
        endcase
    end

    // shared multiplier: scale by step, then multiply by reciprocal to divide by RAMP_STEPS
    assign w_op_a = (r_state == ST_MUL) ? 14'(w_base_comp) : r_acc;
    assign w_op_b = (r_state == ST_MUL) ? 15'(r_step) : tcbl_pkg::RECIP;
    assign w_mul  = w_op_a * w_op_b;

    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || i_ready);
    assign w_grp_inc  = GCW'(r_grp) + GCW'(1);

    always_comb begin
        n_step    = r_step;
        n_falling = r_falling;
        n_grp     = r_grp;
        if (r_found) begin
            n_step    = tcbl_pkg::RAMP_MAX;
            n_falling = 1'b0;
        end else if (!r_falling) begin
            if (r_step + 6'd1 >= tcbl_pkg::RAMP_MAX) begin
                n_step    = tcbl_pkg::RAMP_MAX;
                n_falling = 1'b1;
            end else begin
                n_step = r_step + 6'd1;
            end
        end else begin
            if (r_step > 6'd1) begin
                n_step = r_step - 6'd1;
            end else begin
                n_step    = 6'd0;
                n_falling = 1'b0;
                n_grp     = (w_grp_inc >= w_ngroups) ? '0 : GIW'(w_grp_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_count <= 4'd15;
            r_thr_count <= 4'd10;
        end else if (w_cfg_wr) begin
            if (i_paddr[2] == 1'(tcbl_pkg::REG_THR_COUNT)) begin
                r_thr_count <= i_pwdata[3:0];
            end else begin
                r_grp_count <= i_pwdata[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < GROUP_ENTRIES; g++) begin
                r_base[g] <= '{tcbl_pkg::BASE_RESET, tcbl_pkg::BASE_RESET,
                               tcbl_pkg::BASE_RESET};
            end
            for (int t = 0; t < THRESHOLD_ENTRIES; t++) begin
                r_thr_lvl[t] <= 16'(200 * (t + 1));
                r_thr_col[t] <= (t < tcbl_pkg::PRESET_COUNT) ? tcbl_pkg::PRESET[t] : '0;
            end
        end else if (w_accept) begin
            unique case (i_kind)
                tcbl_pkg::KIND_BASE: begin
                    if (7'(i_entry_index) < 7'(w_ngroups)) begin
                        r_base[GIW'(i_entry_index)] <= '{i_red_in, i_green_in, i_blue_in};
                    end
                end
                tcbl_pkg::KIND_THR: begin
                    if (7'(i_entry_index) < 7'(w_nthr)) begin
                        r_thr_lvl[TIW'(i_entry_index)] <= i_threshold_level;
                        r_thr_col[TIW'(i_entry_index)] <= '{i_red_in, i_green_in, i_blue_in};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_grp       <= '0;
            r_step      <= 6'd0;
            r_falling   <= 1'b0;
            r_last_mode <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_k         <= tcbl_pkg::COMP_RED;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_kind == tcbl_pkg::KIND_FRAME)) begin
                        r_sample <= i_sensor_sample;
                        r_idx    <= w_nthr;
                        if (GCW'(r_grp) >= w_ngroups) begin
                            r_grp <= '0;
                        end
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_hit) begin
                        r_found     <= 1'b1;
                        r_match     <= w_scan_addr;
                        r_last_mode <= 1'b1;
                        r_col       <= r_thr_col[w_scan_addr];
                        r_state     <= ST_OUT;
                    end else if (r_idx <= TCW'(1)) begin
                        r_found     <= 1'b0;
                        r_match     <= '0;
                        r_last_mode <= 1'b0;
                        if (r_last_mode) begin
                            r_step    <= 6'd0;
                            r_falling <= 1'b0;
                        end
                        r_k         <= tcbl_pkg::COMP_RED;
                        r_state     <= ST_MUL;
                    end else begin
                        r_idx <= r_idx - TCW'(1);
                    end
                end
                ST_MUL: begin
                    r_acc   <= w_mul[13:0];
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    case (r_k)
                        tcbl_pkg::COMP_RED:   r_col.red   <= w_mul[tcbl_pkg::RECIP_SHIFT +: 8];
                        tcbl_pkg::COMP_GREEN: r_col.green <= w_mul[tcbl_pkg::RECIP_SHIFT +: 8];
                        default:              r_col.blue  <= w_mul[tcbl_pkg::RECIP_SHIFT +: 8];
                    endcase
                    if (r_k == tcbl_pkg::COMP_BLUE) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_step      <= n_step;
                        r_falling   <= n_falling;
                        r_grp       <= n_grp;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_col   <= r_col;
            r_out_mode  <= r_found;
            r_out_match <= 4'(r_match);
            r_out_group <= 4'(r_grp);
            r_out_step  <= r_found ? tcbl_pkg::RAMP_MAX : r_step;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_red_out           = r_out_col.red;
    assign o_green_out         = r_out_col.green;
    assign o_blue_out          = r_out_col.blue;
    assign o_threshold_mode    = r_out_mode;
    assign o_matched_threshold = r_out_match;
    assign o_active_group      = r_out_group;
    assign o_ramp_step         = r_out_step;

endmodule

`default_nettype wire

/* rtl/core/tcbl_checker.sv */
`default_nettype none

module tcbl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [1:0]  i_kind,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_red_out,
    input wire logic        o_threshold_mode,
    input wire logic [3:0]  o_matched_threshold,
    input wire logic [5:0]  o_ramp_step
);

    // write requests never produce a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_kind != tcbl_pkg::KIND_FRAME)) |=> !$rose(o_valid))
        else $error("result after write request");

    a_thr_full_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_threshold_mode) |-> (o_ramp_step == tcbl_pkg::RAMP_MAX))
        else $error("threshold mode without full step");

    a_breath_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_threshold_mode) |->
            ((o_matched_threshold == 4'd0) && (o_ramp_step <= tcbl_pkg::RAMP_MAX)))
        else $error("breathing result fields out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_red_out) && $stable(o_ramp_step)))
        else $error("stalled result changed");

endmodule

bind threshold_color_breathing_led tcbl_checker u_tcbl_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_ready             (o_ready),
    .i_kind              (i_kind),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_red_out           (o_red_out),
    .o_threshold_mode    (o_threshold_mode),
    .o_matched_threshold (o_matched_threshold),
    .o_ramp_step         (o_ramp_step)
);

`default_nettype wire
